### hw/rtl/small_matrix_mul_add_sub_defines.svh
// Assertion macros used by the top-level RTL
`ifndef SMALL_MATRIX_MUL_ADD_SUB_DEFINES_SVH
`define SMALL_MATRIX_MUL_ADD_SUB_DEFINES_SVH
`ifndef SYNTHESIS
`define SMM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assert failed");
`define SMM_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assert failed");
`else
`define SMM_ASSERT(label, clk, rst, prop)
`define SMM_ASSERT_NR(label, clk, prop)
`endif
`endif

### hw/rtl/smm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package smm_pkg;
   localparam int MaxDim   = 8;
   localparam int Depth    = MaxDim * MaxDim;
   localparam int AddrW    = $clog2(Depth);
   localparam int DimW     = 4;
   localparam int IdxW     = $clog2(MaxDim);
   localparam logic [1:0] MODE_ADD = 2'd0;
   localparam logic [1:0] MODE_SUB = 2'd1;
   localparam logic [1:0] MODE_MUL = 2'd2;
   localparam logic [2:0] REG_MODE   = 3'd0;
   localparam logic [2:0] REG_ROWS_A = 3'd1;
   localparam logic [2:0] REG_COLS_A = 3'd2;
   localparam logic [2:0] REG_ROWS_B = 3'd3;
   localparam logic [2:0] REG_COLS_B = 3'd4;

   // control word handed along the MAC chain
   typedef struct packed {
      logic            valid;
      logic            first;  // clear accumulator
      logic            emit;   // term completes the sum
      logic [1:0]      op;
      logic [IdxW-1:0] row;
      logic [IdxW-1:0] col;
      logic            last;
   } ctl_type;
endpackage
`default_nettype wire

### hw/rtl/small_matrix_mul_add_sub.sv
// channel | direction | handshake          | payload
// req     | in        | start / busy       | req_element
// rsp     | out       | rsp_strobe         | rsp_value rsp_row rsp_col rsp_last rsp_size_error
// csr     | in        | csr_valid/csr_ready| csr_index csr_wdata
// Loading accepts a word whenever start is high; busy is low while loading.
// After the last B word the sequencer walks the result: one term per cycle
// through a read stage and a multiply and accumulate chain of cells.
// Reset is synchronous, active high; results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "small_matrix_mul_add_sub_defines.svh"
module small_matrix_mul_add_sub import smm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_element,
   output logic             rsp_strobe,
   output logic [31:0]      rsp_value,
   output logic [2:0]       rsp_row,
   output logic [2:0]       rsp_col,
   output logic             rsp_last,
   output logic             rsp_size_error,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   localparam logic [1:0] ST_LOAD = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_ERR  = 2'd2;
   localparam logic [1:0] ST_WAIT = 2'd3;

   logic [1:0] mode_ff;
   logic [DimW-1:0] ra_ff, ca_ff, rb_ff, cb_ff;
   logic [1:0] st_ff;
   logic [7:0] cnt_ff;
   logic [IdxW-1:0] i_ff, j_ff, k_ff;
   logic [2:0] drain_ff;
   logic accept, dims_ok, shape_ok, done_load, is_a;
   logic [7:0] na, total, cnt_nx, bi;
   logic [IdxW:0] kl;
   logic [DimW:0] inner;
   logic [AddrW-1:0] a_addr, b_addr, wr_addr;
   logic [31:0] a_q, b_q;
   logic wr_a, wr_b, step_last;
   ctl_type ctl_s0, ctl_s1, ctl_c1, ctl_c2;
   logic [31:0] av1, bv1, av2, bv2;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ADD;
         ra_ff <= 4'd8; ca_ff <= 4'd8; rb_ff <= 4'd8; cb_ff <= 4'd8;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_MODE:   mode_ff <= csr_wdata[1:0];
            REG_ROWS_A: ra_ff <= csr_wdata[3:0];
            REG_COLS_A: ca_ff <= csr_wdata[3:0];
            REG_ROWS_B: rb_ff <= csr_wdata[3:0];
            REG_COLS_B: cb_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   function automatic logic dok(input logic [DimW-1:0] d);
      return d != '0 && d <= DimW'(MaxDim);
   endfunction

   always_comb begin
      dims_ok  = dok(ra_ff) && dok(ca_ff) && dok(rb_ff) && dok(cb_ff);
      na       = 8'(ra_ff) * 8'(ca_ff);
      total    = na + 8'(rb_ff) * 8'(cb_ff);
      accept   = start && !busy;
      cnt_nx   = cnt_ff + 8'd1;
      done_load = cnt_nx == 8'd0 || cnt_nx >= total;
      is_a     = cnt_ff < na;
      bi       = cnt_ff - na;
      wr_a     = accept && dims_ok && is_a && cnt_ff < 8'(Depth);
      wr_b     = accept && dims_ok && !is_a && bi < 8'(Depth);
      wr_addr  = is_a ? cnt_ff[AddrW-1:0] : bi[AddrW-1:0];
      unique case (mode_ff)
         MODE_ADD, MODE_SUB: shape_ok = ra_ff == rb_ff && ca_ff == cb_ff;
         MODE_MUL:           shape_ok = ca_ff == rb_ff;
         default:            shape_ok = 1'b0;
      endcase
      inner = (mode_ff == MODE_MUL) ? {1'b0, ca_ff} : 5'd1;
      kl    = IdxW'(k_ff) + 1'b1;
      step_last = kl == inner[IdxW:0];
      if (mode_ff == MODE_MUL) begin
         a_addr = AddrW'(i_ff) * AddrW'(ca_ff) + AddrW'(k_ff);
         b_addr = AddrW'(k_ff) * AddrW'(cb_ff) + AddrW'(j_ff);
      end else begin
         a_addr = AddrW'(i_ff) * AddrW'(ca_ff) + AddrW'(j_ff);
         b_addr = a_addr;
      end
      busy = st_ff != ST_LOAD;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_LOAD; cnt_ff <= '0; i_ff <= '0; j_ff <= '0; k_ff <= '0;
         drain_ff <= '0;
      end else begin
         unique case (st_ff)
            ST_LOAD: if (accept) begin
               if (!dims_ok) begin
                  cnt_ff <= '0; st_ff <= ST_ERR;
               end else if (done_load) begin
                  cnt_ff <= '0; i_ff <= '0; j_ff <= '0; k_ff <= '0;
                  st_ff <= shape_ok ? ST_RUN : ST_ERR;
               end else cnt_ff <= cnt_nx;
            end
            ST_RUN: begin
               if (step_last) begin
                  k_ff <= '0;
                  if (4'(j_ff) + 4'd1 == ((mode_ff == MODE_MUL) ? cb_ff : ca_ff)) begin
                     j_ff <= '0;
                     if (4'(i_ff) + 4'd1 == ra_ff) begin
                        st_ff <= ST_WAIT; drain_ff <= 3'd4;
                     end else i_ff <= i_ff + 1'b1;
                  end else j_ff <= j_ff + 1'b1;
               end else k_ff <= k_ff + 1'b1;
            end
            ST_ERR: st_ff <= ST_LOAD;
            default: begin
               drain_ff <= drain_ff - 3'd1;
               if (drain_ff == 3'd1) st_ff <= ST_LOAD;
            end
         endcase
      end
   end

   smm_ram #(.Width(32), .Depth(Depth)) u_ram_a (.clock(clock), .wr_en(wr_a),
      .wr_addr(wr_addr), .wr_data(req_element), .rd_addr(a_addr), .rd_data(a_q));
   smm_ram #(.Width(32), .Depth(Depth)) u_ram_b (.clock(clock), .wr_en(wr_b),
      .wr_addr(wr_addr), .wr_data(req_element), .rd_addr(b_addr), .rd_data(b_q));

   always_comb begin
      ctl_s0.valid = st_ff == ST_RUN;
      ctl_s0.first = k_ff == '0;
      ctl_s0.emit  = step_last;
      ctl_s0.op    = mode_ff;
      ctl_s0.row   = i_ff;
      ctl_s0.col   = j_ff;
      ctl_s0.last  = step_last && 4'(i_ff) + 4'd1 == ra_ff
                     && 4'(j_ff) + 4'd1 == ((mode_ff == MODE_MUL) ? cb_ff : ca_ff);
   end
   always_ff @(posedge clock) begin
      if (reset) ctl_s1 <= '0;
      else ctl_s1 <= ctl_s0;
   end

   smm_cell u_mul (.clock(clock), .reset(reset), .kind(2'd0), .ctl_in(ctl_s1),
      .a_in(a_q), .b_in(b_q), .ctl_out(ctl_c1), .a_out(av1), .b_out(bv1));
   smm_cell u_acc (.clock(clock), .reset(reset), .kind(2'd1), .ctl_in(ctl_c1),
      .a_in(av1), .b_in(bv1), .ctl_out(ctl_c2), .a_out(av2), .b_out(bv2));

   logic err_ff;
   always_ff @(posedge clock) begin
      if (reset) err_ff <= 1'b0;
      else err_ff <= (st_ff == ST_ERR);
   end
   always_comb begin
      rsp_strobe     = (ctl_c2.valid && ctl_c2.emit) || err_ff;
      rsp_value      = err_ff ? 32'd0 : av2;
      rsp_row        = err_ff ? '0 : ctl_c2.row;
      rsp_col        = err_ff ? '0 : ctl_c2.col;
      rsp_last       = err_ff || ctl_c2.last;
      rsp_size_error = err_ff;
   end
   logic unused_b;
   assign unused_b = ^bv2;

   `SMM_ASSERT(a_busy_run, clock, reset, (st_ff == ST_RUN) |-> busy)
   `SMM_ASSERT(a_err_strobe, clock, reset, err_ff |-> (rsp_strobe && rsp_last))
   `SMM_ASSERT(a_no_accept_run, clock, reset, (st_ff == ST_RUN) |=> !$past(accept))
endmodule
`default_nettype wire

### hw/rtl/smm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module smm_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

### hw/rtl/smm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One stage of the arithmetic chain. Stage kind is set by a port tied at the top.
module smm_cell import smm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [1:0]  kind,    // 0 multiply, 1 accumulate
   input  var  ctl_type     ctl_in,
   input  wire logic [31:0] a_in,
   input  wire logic [31:0] b_in,
   output ctl_type          ctl_out,
   output logic [31:0]      a_out,
   output logic [31:0]      b_out
);
   ctl_type     ctl_ff;
   logic [31:0] a_ff, b_ff, a_in_d, b_in_d;
   logic [63:0] prod;
   always_comb begin
      prod = 64'(a_in) * 64'(b_in);
      a_in_d = a_in;
      b_in_d = b_in;
      unique case (kind)
         2'd0: begin
            // multiply stage: a carries the result term (sum, difference or product), b passes b_in on
            unique case (ctl_in.op)
               MODE_ADD: a_in_d = a_in + b_in;
               MODE_SUB: a_in_d = a_in - b_in;
               default:  a_in_d = prod[31:0];
            endcase
         end
         default: begin
            // accumulate: b_ff holds running sum
            a_in_d = ctl_in.first ? a_in : a_in + b_ff;
            b_in_d = a_in_d;
         end
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) ctl_ff <= '0;
      else ctl_ff <= ctl_in;
      a_ff <= a_in_d;
      if (ctl_in.valid) b_ff <= b_in_d;
   end
   assign ctl_out = ctl_ff;
   assign a_out   = a_ff;
   assign b_out   = b_ff;
endmodule
`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import smm_pkg::*;

   typedef struct {
      logic [31:0] value;
      logic [2:0]  row;
      logic [2:0]  col;
      logic        last;
      logic        err;
   } result_t;

   typedef struct {
      bit          is_reg;
      logic [2:0]  idx;
      logic [31:0] data;
      bit          typed;   // single error word typed in below
   } stim_t;

   localparam int WatchLimit = 5000;
   localparam int Drain = 12;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic [31:0] req_element = '0;
   logic        csr_valid = 0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;
   wire         busy, rsp_strobe, rsp_last, rsp_size_error, csr_ready;
   wire  [31:0] rsp_value;
   wire  [2:0]  rsp_row, rsp_col;

   small_matrix_mul_add_sub dut (.*);

   always #4 clock = ~clock;

   // shadow of the block
   logic [1:0]  op_mode;
   logic [3:0]  dim_ra, dim_ca, dim_rb, dim_cb;
   logic [31:0] store_a [64];
   logic [31:0] store_b [64];
   logic [7:0]  loaded;
   result_t     pending [$];
   int          failures = 0;
   int          items = 0;
   int          idle_cycles = 0;

   function automatic bit dim_valid(logic [3:0] d);
      return d >= 1 && d <= MaxDim;
   endfunction

   function automatic result_t err_word();
      result_t r;
      r.value = '0; r.row = '0; r.col = '0; r.last = 1; r.err = 1;
      return r;
   endfunction

   function automatic void compute_matrix(logic [31:0] elem);
      int na, total, rr, cc;
      logic [31:0] acc;
      result_t r;
      if (!(dim_valid(dim_ra) && dim_valid(dim_ca) && dim_valid(dim_rb) && dim_valid(dim_cb)))
      begin
         loaded = 0;
         pending.push_back(err_word());
         return;
      end
      na = dim_ra * dim_ca;
      total = na + dim_rb * dim_cb;
      if (loaded < na) store_a[loaded] = elem;
      else if (loaded - na < 64) store_b[loaded - na] = elem;
      loaded = loaded + 1;
      if (loaded != 0 && loaded < total) return;
      loaded = 0;
      if (op_mode == MODE_ADD || op_mode == MODE_SUB) begin
         if (dim_ra != dim_rb || dim_ca != dim_cb) begin
            pending.push_back(err_word());
            return;
         end
         rr = dim_ra; cc = dim_ca;
      end else if (op_mode == MODE_MUL && dim_ca == dim_rb) begin
         rr = dim_ra; cc = dim_cb;
      end else begin
         pending.push_back(err_word());
         return;
      end
      for (int i = 0; i < rr; i++)
         for (int j = 0; j < cc; j++) begin
            if (op_mode == MODE_ADD) acc = store_a[i*cc+j] + store_b[i*cc+j];
            else if (op_mode == MODE_SUB) acc = store_a[i*cc+j] - store_b[i*cc+j];
            else begin
               acc = '0;
               for (int k = 0; k < dim_ca; k++)
                  acc = acc + store_a[i*dim_ca+k] * store_b[k*cc+j];
            end
            r.value = acc; r.row = 3'(i); r.col = 3'(j);
            r.last = (i == rr - 1) && (j == cc - 1); r.err = 0;
            pending.push_back(r);
         end
   endfunction

   task automatic pause_input(int n);
      @(negedge clock) start <= 0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic send_word(logic [31:0] elem, bit typed);
      @(negedge clock);
      start <= 1;
      req_element <= elem;
      do @(posedge clock); while (busy);
      compute_matrix(elem);
      if (typed) begin
         void'(pending.pop_back());
         pending.push_back(err_word());
      end
      items++;
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] data);
      @(negedge clock) start <= 0;
      while (pending.size() != 0) @(posedge clock);
      repeat (Drain) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1; csr_index <= idx; csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_MODE:   op_mode = data[1:0];
         REG_ROWS_A: dim_ra = data[3:0];
         REG_COLS_A: dim_ca = data[3:0];
         REG_ROWS_B: dim_rb = data[3:0];
         REG_COLS_B: dim_cb = data[3:0];
         default: ;
      endcase
      @(negedge clock) csr_valid <= 0;
   endtask

   always @(posedge clock) begin
      result_t e;
      if (!reset && rsp_strobe) begin
         if (pending.size() == 0) begin
            $error("unexpected result word value=%h", rsp_value);
            failures++;
         end else begin
            e = pending.pop_front();
            if (rsp_value !== e.value) begin
               $error("value: expected %h, got %h", e.value, rsp_value); failures++;
            end
            if (rsp_row !== e.row) begin
               $error("row: expected %0d, got %0d", e.row, rsp_row); failures++;
            end
            if (rsp_col !== e.col) begin
               $error("col: expected %0d, got %0d", e.col, rsp_col); failures++;
            end
            if (rsp_last !== e.last) begin
               $error("last: expected %0d, got %0d", e.last, rsp_last); failures++;
            end
            if (rsp_size_error !== e.err) begin
               $error("size_error: expected %0d, got %0d", e.err, rsp_size_error);
               failures++;
            end
         end
      end
   end

   // watchdog: cycles with no handshake of any kind
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic logic [3:0] pick_dim();
      if ($urandom_range(0, 9) == 0) return 4'd8;
      return 4'($urandom_range(1, 3));
   endfunction

   function automatic logic [31:0] pick_elem();
      case ($urandom_range(0, 7))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'hffff_ffff;
         3: return $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   function automatic bit dut_mode_mul();
      return op_mode == MODE_MUL;
   endfunction

   stim_t directed [] = '{
      '{1, REG_ROWS_A, 32'd0,         0}, '{0, 0, 32'h7fff_ffff, 1},
      '{0, 0, 32'h8000_0000, 1},           '{1, REG_ROWS_A, 32'hffff_fff9, 0},
      '{0, 0, 32'hffff_ffff, 1},           '{1, REG_ROWS_A, 32'd15, 0},
      '{0, 0, 32'h0000_0000, 1},           '{1, REG_ROWS_A, 32'd1, 0},
      '{1, REG_COLS_A, 32'd1, 0},          '{1, REG_ROWS_B, 32'd1, 0},
      '{1, REG_COLS_B, 32'd1, 0},          '{0, 0, 32'h7fff_ffff, 0},
      '{0, 0, 32'h0000_0001, 0},           '{1, REG_MODE, MODE_SUB, 0},
      '{0, 0, 32'h8000_0000, 0},           '{0, 0, 32'h0000_0001, 0},
      '{1, REG_MODE, MODE_MUL, 0},         '{0, 0, 32'hffff_ffff, 0},
      '{0, 0, 32'h8000_0000, 0},           '{1, REG_MODE, 32'd3, 0},
      '{0, 0, 32'd5, 0},                   '{0, 0, 32'd6, 1},
      '{1, REG_MODE, MODE_ADD, 0},         '{1, REG_ROWS_B, 32'd2, 0},
      '{0, 0, 32'd1, 0},                   '{0, 0, 32'd2, 0},
      '{0, 0, 32'd3, 1},                   '{1, REG_MODE, MODE_MUL, 0},
      '{1, REG_COLS_A, 32'd2, 0},          '{0, 0, 32'd7, 0},
      '{0, 0, 32'd8, 0},                   '{0, 0, 32'd9, 0},
      '{0, 0, 32'd10, 0}
   };

   initial begin
      logic [3:0] d [4];
      int kind, total;
      op_mode = MODE_ADD;
      dim_ra = 8; dim_ca = 8; dim_rb = 8; dim_cb = 8;
      loaded = 0;
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 0;

      foreach (directed[n]) begin
         if (directed[n].is_reg) write_reg(directed[n].idx, directed[n].data);
         else send_word(directed[n].data, directed[n].typed);
      end

      while (items < 330) begin
         kind = $urandom_range(0, 11);
         for (int i = 0; i < 4; i++) d[i] = pick_dim();
         if (kind == 0) d[$urandom_range(0, 3)] = $urandom_range(0, 1) ? 4'd0
                                                  : 4'($urandom_range(9, 15));
         write_reg(REG_MODE, 32'({$urandom, 2'b00} |
                   (kind == 1 ? 32'd3 : 32'($urandom_range(0, 2)))));
         if (kind >= 3) begin
            if (dut_mode_mul()) d[2] = d[1];
            else begin d[2] = d[0]; d[3] = d[1]; end
         end
         write_reg(REG_ROWS_A, 32'({$urandom, 4'h0} | d[0]));
         write_reg(REG_COLS_A, 32'({$urandom, 4'h0} | d[1]));
         write_reg(REG_ROWS_B, 32'({$urandom, 4'h0} | d[2]));
         write_reg(REG_COLS_B, 32'({$urandom, 4'h0} | d[3]));
         total = (kind == 0) ? $urandom_range(1, 3) : d[0]*d[1] + d[2]*d[3];
         for (int i = 0; i < total; i++) begin
            if (items < 280 && $urandom_range(0, 4) == 0) pause_input($urandom_range(1, 14));
            send_word(pick_elem(), 0);
         end
      end

      @(negedge clock) start <= 0;
      while (pending.size() != 0) @(posedge clock);
      repeat (Drain) @(posedge clock);
      if (failures == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/smm_pkg.sv
hw/rtl/smm_ram.sv
hw/rtl/smm_cell.sv
hw/rtl/small_matrix_mul_add_sub.sv
verif/testbench.sv
